[hdl/tds_pkg.sv]
package tds_pkg;

	localparam int MAX_TRIANGLES_DEF = 64;
	localparam int VERTICES_PER_POLYGON = 3;
	localparam int IDX_W = 16;
	localparam int COORD_W = 24;
	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W = 2 * DIFF_W;
	localparam int DIST_W = 52;
	localparam int TRI_IDX_W = IDX_W * VERTICES_PER_POLYGON;
	localparam int PEND_W = IDX_W * (VERTICES_PER_POLYGON - 1);
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAMERA_X = 2'd0,
		CFG_CAMERA_Y = 2'd1,
		CFG_CAMERA_Z = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [TRI_IDX_W-1:0] idx;
		logic [DIST_W-1:0]    sq_dist;
	} entry_t;

	typedef struct packed {
		logic   insert;
		logic   pop;
		entry_t ent;
	} chain_ctrl_t;

	typedef struct packed {
		logic             valid;
		logic             set_end;
		logic [IDX_W-1:0] idx;
		logic [SQ_W-1:0]  sq_x;
		logic [SQ_W-1:0]  sq_y;
		logic [SQ_W-1:0]  sq_z;
	} vtx_sq_t;

endpackage

[hdl/tds_dist.sv]
module tds_dist (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [tds_pkg::IDX_W-1:0]         vertex_index,
	input  logic signed [tds_pkg::COORD_W-1:0] coord_x,
	input  logic signed [tds_pkg::COORD_W-1:0] coord_y,
	input  logic signed [tds_pkg::COORD_W-1:0] coord_z,
	input  logic                              set_end,
	input  logic signed [tds_pkg::COORD_W-1:0] camera_x,
	input  logic signed [tds_pkg::COORD_W-1:0] camera_y,
	input  logic signed [tds_pkg::COORD_W-1:0] camera_z,
	output tds_pkg::vtx_sq_t                  vtx,
	output logic                              end_s1
);

	logic                             valid_s1;
	logic [tds_pkg::IDX_W-1:0]        idx_s1;
	logic [tds_pkg::DIFF_W-1:0]       mag_x_s1, mag_y_s1, mag_z_s1;
	logic signed [tds_pkg::DIFF_W-1:0] dx, dy, dz;
	logic                             valid_s2;
	logic                             end_s2;
	logic [tds_pkg::IDX_W-1:0]        idx_s2;
	logic [tds_pkg::SQ_W-1:0]         sq_x_s2, sq_y_s2, sq_z_s2;

	assign dx = {coord_x[tds_pkg::COORD_W-1], coord_x} - {camera_x[tds_pkg::COORD_W-1], camera_x};
	assign dy = {coord_y[tds_pkg::COORD_W-1], coord_y} - {camera_y[tds_pkg::COORD_W-1], camera_y};
	assign dz = {coord_z[tds_pkg::COORD_W-1], coord_z} - {camera_z[tds_pkg::COORD_W-1], camera_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			end_s1   <= 1'b0;
			valid_s2 <= 1'b0;
			end_s2   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			end_s1   <= accept & set_end;
			valid_s2 <= valid_s1;
			end_s2   <= end_s1;
		end
	end

	// magnitudes first, one multiplier per axis in the next stage
	always_ff @(posedge clk) begin
		idx_s1   <= vertex_index;
		mag_x_s1 <= dx[tds_pkg::DIFF_W-1] ? tds_pkg::DIFF_W'(-dx) : tds_pkg::DIFF_W'(dx);
		mag_y_s1 <= dy[tds_pkg::DIFF_W-1] ? tds_pkg::DIFF_W'(-dy) : tds_pkg::DIFF_W'(dy);
		mag_z_s1 <= dz[tds_pkg::DIFF_W-1] ? tds_pkg::DIFF_W'(-dz) : tds_pkg::DIFF_W'(dz);
		idx_s2   <= idx_s1;
		sq_x_s2  <= tds_pkg::SQ_W'(mag_x_s1) * tds_pkg::SQ_W'(mag_x_s1);
		sq_y_s2  <= tds_pkg::SQ_W'(mag_y_s1) * tds_pkg::SQ_W'(mag_y_s1);
		sq_z_s2  <= tds_pkg::SQ_W'(mag_z_s1) * tds_pkg::SQ_W'(mag_z_s1);
	end

	assign vtx.valid   = valid_s2;
	assign vtx.set_end = end_s2;
	assign vtx.idx     = idx_s2;
	assign vtx.sq_x    = sq_x_s2;
	assign vtx.sq_y    = sq_y_s2;
	assign vtx.sq_z    = sq_z_s2;

endmodule

[hdl/tds_cell.sv]
module tds_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tds_pkg::chain_ctrl_t  ctrl,
	input  tds_pkg::entry_t       left_ent,
	input  logic                  left_keep,
	input  logic                  left_valid,
	input  tds_pkg::entry_t       right_ent,
	input  logic                  right_valid,
	output tds_pkg::entry_t       ent,
	output logic                  valid,
	output logic                  keep
);

	tds_pkg::entry_t ent_q;
	logic            valid_q;

	// entries sit farthest first; a new one lands behind every entry at least as far
	assign keep  = valid_q && (ent_q.sq_dist >= ctrl.ent.sq_dist);
	assign ent   = ent_q;
	assign valid = valid_q;

	// a cell that shifts in from the left takes the left neighbor's valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end else if (ctrl.insert && !keep) begin
			valid_q <= left_keep | left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			ent_q <= right_ent;
		end else if (ctrl.insert && !keep) begin
			ent_q <= left_keep ? ctrl.ent : left_ent;
		end
	end

endmodule

[hdl/tds_chain.sv]
module tds_chain #(
	parameter int MAX_TRIANGLES = tds_pkg::MAX_TRIANGLES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tds_pkg::chain_ctrl_t ctrl,
	output tds_pkg::entry_t      head_ent
);

	tds_pkg::entry_t ents   [MAX_TRIANGLES];
	logic            valids [MAX_TRIANGLES];
	logic            keeps  [MAX_TRIANGLES];

	genvar g;
	generate
		for (g = 0; g < MAX_TRIANGLES; g++) begin : g_cell
			tds_pkg::entry_t left_ent;
			logic            left_keep;
			logic            left_valid;
			tds_pkg::entry_t right_ent;
			logic            right_valid;

			if (g == 0) begin : g_head
				assign left_ent   = '0;
				assign left_keep  = 1'b1;
				assign left_valid = 1'b1;
			end else begin : g_mid
				assign left_ent   = ents[g-1];
				assign left_keep  = keeps[g-1];
				assign left_valid = valids[g-1];
			end
			if (g == MAX_TRIANGLES - 1) begin : g_tail
				assign right_ent   = '0;
				assign right_valid = 1'b0;
			end else begin : g_body
				assign right_ent   = ents[g+1];
				assign right_valid = valids[g+1];
			end

			tds_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.left_ent    (left_ent),
				.left_keep   (left_keep),
				.left_valid  (left_valid),
				.right_ent   (right_ent),
				.right_valid (right_valid),
				.ent         (ents[g]),
				.valid       (valids[g]),
				.keep        (keeps[g])
			);
		end
	endgenerate

	assign head_ent = ents[0];

endmodule

[hdl/triangle_depth_sorter_top.sv]
// Channel  Direction  Handshake               Beat
// in       sink       in_valid / in_stall     one vertex with set_end mark
// out      source     out_valid / out_stall   one sorted triangle
// cfg      sink       cfg_valid / cfg_ready   camera register write
//
// Vertices enter one per cycle while in_stall is low; a triangle passes the
// magnitude, square and assembly registers into the insertion chain, with no
// stall while a set loads. After set_end, in_stall stays high while the mark
// passes end_s1, end_s2 and end_s3, then through the drain. Then one triangle
// per cycle leaves the chain head while out_stall is low, one per stored entry.
// Output stall with out_valid high freezes the drain and holds the output beat.
// Reset clears the set state and the chain; cfg_ready is always high.
module triangle_depth_sorter_top #(
	parameter int MAX_TRIANGLES = tds_pkg::MAX_TRIANGLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tds_pkg::IDX_W-1:0]           vertex_index,
	input  logic signed [tds_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [tds_pkg::COORD_W-1:0]  coord_y,
	input  logic signed [tds_pkg::COORD_W-1:0]  coord_z,
	input  logic                                set_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tds_pkg::IDX_W-1:0]           first_index,
	output logic [tds_pkg::IDX_W-1:0]           second_index,
	output logic [tds_pkg::IDX_W-1:0]           third_index,
	output logic [tds_pkg::DIST_W-1:0]          nearest_distance,
	output logic                                overflowed,
	output logic                                final_result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tds_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tds_pkg::COORD_W-1:0]         cfg_data
);

	localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRIANGLES);

	logic signed [tds_pkg::COORD_W-1:0] cam_x_q, cam_y_q, cam_z_q;

	logic                         accept;
	logic                         end_s1;
	tds_pkg::vtx_sq_t             vtx;

	logic [1:0]                   pos_q;
	logic [tds_pkg::DIST_W-1:0]   min_q;
	logic [tds_pkg::PEND_W-1:0]   pend_q;
	logic [CNT_W-1:0]             count_q;
	logic                         ovf_q;

	logic [tds_pkg::DIST_W-1:0]   sum;
	logic [tds_pkg::DIST_W-1:0]   cur_min;
	logic [CNT_W-1:0]             count_nx;
	logic                         ovf_nx;

	logic                         ins_s3;
	tds_pkg::entry_t              ins_ent_s3;
	logic                         end_s3;
	logic [CNT_W-1:0]             cnt_s3;
	logic                         ovf_s3;

	logic                         drain_q;
	logic [CNT_W-1:0]             rem_q;
	logic                         run_ovf_q;
	logic                         pop;
	tds_pkg::chain_ctrl_t         ctrl;
	tds_pkg::entry_t              head_ent;

	logic                         out_valid_q;
	tds_pkg::entry_t              out_ent_q;
	logic                         out_ovf_q;
	logic                         out_final_q;

	// camera registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tds_pkg::CFG_CAMERA_X: cam_x_q <= cfg_data;
				tds_pkg::CFG_CAMERA_Y: cam_y_q <= cfg_data;
				tds_pkg::CFG_CAMERA_Z: cam_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold off new vertices while a set end is in flight or the run drains
	assign in_stall = end_s1 | (vtx.valid & vtx.set_end) | end_s3 | drain_q;
	assign accept   = in_valid & ~in_stall;

	tds_dist u_dist (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.set_end      (set_end),
		.camera_x     (cam_x_q),
		.camera_y     (cam_y_q),
		.camera_z     (cam_z_q),
		.vtx          (vtx),
		.end_s1       (end_s1)
	);

	// triangle assembly
	assign sum = tds_pkg::DIST_W'(vtx.sq_x) + tds_pkg::DIST_W'(vtx.sq_y)
	           + tds_pkg::DIST_W'(vtx.sq_z);
	assign cur_min = (sum < min_q) ? sum : min_q;

	always_comb begin
		count_nx = count_q;
		ovf_nx   = ovf_q;
		if (pos_q == 2'(tds_pkg::VERTICES_PER_POLYGON - 1)) begin
			if (count_q < CNT_MAX) begin
				count_nx = count_q + CNT_W'(1);
			end else begin
				ovf_nx = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			min_q   <= '1;
			pend_q  <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			ins_s3  <= 1'b0;
			end_s3  <= 1'b0;
		end else begin
			ins_s3 <= 1'b0;
			end_s3 <= 1'b0;
			if (vtx.valid) begin
				if (pos_q != 2'(tds_pkg::VERTICES_PER_POLYGON - 1)) begin
					if (pos_q[0]) begin
						pend_q[2*tds_pkg::IDX_W-1:tds_pkg::IDX_W] <= vtx.idx;
					end else begin
						pend_q[tds_pkg::IDX_W-1:0] <= vtx.idx;
					end
					pos_q <= pos_q + 2'd1;
					min_q <= cur_min;
				end else begin
					ins_s3 <= (count_q < CNT_MAX);
					pos_q  <= '0;
					pend_q <= '0;
					min_q  <= '1;
				end
				count_q <= count_nx;
				ovf_q   <= ovf_nx;
				if (vtx.set_end) begin
					// start the next set clean; a partial triangle is dropped
					end_s3  <= 1'b1;
					pos_q   <= '0;
					pend_q  <= '0;
					min_q   <= '1;
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vtx.valid) begin
			ins_ent_s3.idx     <= {vtx.idx, pend_q};
			ins_ent_s3.sq_dist <= cur_min;
			cnt_s3             <= count_nx;
			ovf_s3             <= ovf_nx;
		end
	end

	// insertion chain
	assign pop         = drain_q & (~out_valid_q | ~out_stall);
	assign ctrl.insert = ins_s3;
	assign ctrl.pop    = pop;
	assign ctrl.ent    = ins_ent_s3;

	tds_chain #(
		.MAX_TRIANGLES (MAX_TRIANGLES)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.head_ent (head_ent)
	);

	// drain and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q     <= 1'b0;
			rem_q       <= '0;
			run_ovf_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (end_s3) begin
				drain_q   <= (cnt_s3 != '0);
				rem_q     <= cnt_s3;
				run_ovf_q <= ovf_s3;
			end else if (pop) begin
				rem_q <= rem_q - CNT_W'(1);
				if (rem_q == CNT_W'(1)) begin
					drain_q <= 1'b0;
				end
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_ent_q   <= head_ent;
			out_ovf_q   <= run_ovf_q;
			out_final_q <= (rem_q == CNT_W'(1));
		end
	end

	assign out_valid        = out_valid_q;
	assign first_index      = out_ent_q.idx[tds_pkg::IDX_W-1:0];
	assign second_index     = out_ent_q.idx[2*tds_pkg::IDX_W-1:tds_pkg::IDX_W];
	assign third_index      = out_ent_q.idx[3*tds_pkg::IDX_W-1:2*tds_pkg::IDX_W];
	assign nearest_distance = out_ent_q.sq_dist;
	assign overflowed       = out_ovf_q;
	assign final_result     = out_final_q;

	a_drain_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> rem_q != '0)
		else $error("drain active with nothing left");

	a_last_pop_ends: assert property (@(posedge clk) disable iff (!arst_n)
		pop && rem_q == CNT_W'(1) |=> !drain_q)
		else $error("drain continues past last triangle");

	a_no_insert_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.insert && ctrl.pop))
		else $error("chain insert and pop together");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("triangle count beyond capacity");

endmodule
